FILE: rtl/atacc_pkg.sv
package atacc_pkg;

  // word format and matrix shape
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ROWS      = 3;
  localparam int COLS      = 4;
  localparam int NUM_ELEM  = ROWS * COLS;
  localparam int TDATA_W   = NUM_ELEM * DATA_W;

  // full product and exact sum of three shifted products plus translation
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [ROWS-1:0]         vec_t;
  typedef word_t [NUM_ELEM-1:0]     mat_t;

  localparam word_t FX_ONE  = DATA_W'(1 << FRAC_BITS);
  localparam word_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // identity with 1.0 on the diagonal
  function automatic mat_t identity();
    mat_t m;
    m = '0;
    for (int r = 0; r < ROWS; r++) begin
      m[r*COLS+r] = FX_ONE;
    end
    return m;
  endfunction

endpackage

FILE: rtl/atacc_lane.sv
module atacc_lane (
  input  logic              clk,
  input  logic              issue,
  input  atacc_pkg::vec_t   m_row,
  input  atacc_pkg::word_t  m_trans,
  input  atacc_pkg::vec_t   a_col,
  output atacc_pkg::word_t  result
);

  logic signed [atacc_pkg::PROD_W-1:0] prod_r [atacc_pkg::ROWS];
  atacc_pkg::word_t                    trans_r;
  logic signed [atacc_pkg::SUM_W-1:0]  sum;

  // product stage, one multiplier per term
  always_ff @(posedge clk) begin
    if (issue) begin
      for (int k = 0; k < atacc_pkg::ROWS; k++) begin
        prod_r[k] <= $signed(m_row[k]) * $signed(a_col[k]);
      end
      trans_r <= m_trans;
    end
  end

  // exact sum of floored products plus translation, then saturate
  always_comb begin
    sum = atacc_pkg::SUM_W'($signed(trans_r));
    for (int k = 0; k < atacc_pkg::ROWS; k++) begin
      sum = sum + atacc_pkg::SUM_W'(prod_r[k] >>> atacc_pkg::FRAC_BITS);
    end
    if (sum > atacc_pkg::SUM_W'($signed(atacc_pkg::SAT_MAX))) begin
      result = atacc_pkg::SAT_MAX;
    end else if (sum < atacc_pkg::SUM_W'($signed(atacc_pkg::SAT_MIN))) begin
      result = atacc_pkg::SAT_MIN;
    end else begin
      result = atacc_pkg::DATA_W'(sum);
    end
  end

endmodule

FILE: rtl/atacc_state.sv
module atacc_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             retire,
  input  atacc_pkg::mat_t  acc_nxt,
  output atacc_pkg::mat_t  acc
);

  atacc_pkg::mat_t acc_r;

  // accumulator, gathers all lane results at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= atacc_pkg::identity();
    end else if (retire) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/affine_transform_accumulator_top.sv
// Composes a stream of 3x4 affine matrices (signed Q16.16, bottom row
// implied 0 0 0 1) into an accumulator that starts as the identity: each
// transfer M replaces the accumulator A with M * A, products floored by the
// fraction bits and each sum saturated to 32 bits, and one transfer of the
// whole updated matrix follows every input. Both tdata buses carry the twelve
// entries in row-major order, entry 0 in bits 31:0. Twelve lanes work in
// parallel, one per entry, each with three multipliers. A new matrix is
// issued only once the previous one has retired: that is the loop from
// the accumulator through the registered products, adder and saturator.
// An input goes through the input register, the registered products and
// the accumulator, which holds the result; while a result waits, two further
// inputs are held, one as registered products and one in the input register.
module affine_transform_accumulator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // in_r0c0, in_r0c1, ... in_r2c3, 32 bits each
  input  logic [atacc_pkg::TDATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // acc_r0c0, acc_r0c1, ... acc_r2c3, 32 bits each
  output logic [atacc_pkg::TDATA_W-1:0] out_tdata
);

  atacc_pkg::mat_t m_r;
  logic            m_vld_r, m_vld_nxt;
  logic            prod_vld_r, prod_vld_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic            issue, retire, out_free;
  atacc_pkg::mat_t acc, lane_res;
  atacc_pkg::vec_t lane_row [atacc_pkg::NUM_ELEM];
  atacc_pkg::vec_t lane_col [atacc_pkg::NUM_ELEM];
  atacc_pkg::word_t lane_trans [atacc_pkg::NUM_ELEM];

  // pipeline control
  assign out_free  = !out_tvalid_r || out_tready;
  assign issue     = m_vld_r && !prod_vld_r;
  assign retire    = prod_vld_r && out_free;
  assign in_tready = !m_vld_r || issue;

  always_comb begin
    m_vld_nxt      = (m_vld_r && !issue) || (in_tvalid && in_tready);
    prod_vld_nxt   = issue || (prod_vld_r && !retire);
    out_tvalid_nxt = retire || (out_tvalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r      <= 1'b0;
      prod_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      m_vld_r      <= m_vld_nxt;
      prod_vld_r   <= prod_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // input holding register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      m_r <= atacc_pkg::mat_t'(in_tdata);
    end
  end

  // one lane per entry: row of M against column of A
  for (genvar r = 0; r < atacc_pkg::ROWS; r++) begin : g_row
    for (genvar c = 0; c < atacc_pkg::COLS; c++) begin : g_col
      localparam int E = r * atacc_pkg::COLS + c;
      for (genvar k = 0; k < atacc_pkg::ROWS; k++) begin : g_term
        assign lane_row[E][k] = m_r[r*atacc_pkg::COLS+k];
        assign lane_col[E][k] = acc[k*atacc_pkg::COLS+c];
      end
      if (c == atacc_pkg::COLS - 1) begin : g_trans
        assign lane_trans[E] = m_r[r*atacc_pkg::COLS+atacc_pkg::COLS-1];
      end else begin : g_lin
        assign lane_trans[E] = '0;
      end
      atacc_lane u_lane (
        .clk     (clk),
        .issue   (issue),
        .m_row   (lane_row[E]),
        .m_trans (lane_trans[E]),
        .a_col   (lane_col[E]),
        .result  (lane_res[E])
      );
    end
  end

  // merge lane results into the accumulator, which also drives the output
  atacc_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .retire  (retire),
    .acc_nxt (lane_res),
    .acc     (acc)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = acc;

  // a stalled result keeps the accumulator untouched
  a_stall_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> $stable(acc))
    else $error("accumulator changed under a stalled result");

  // products must retire before the next issue reads the accumulator
  a_no_back_issue: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> !issue)
    else $error("issue while products still pending");

  // a result only appears after products retire
  a_valid_from_retire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(retire))
    else $error("result valid without a retire");

endmodule
